>>> hdl/disconnection_alarm_qualifier_unit_macros.svh
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while rst_n is low.
`ifndef DISCONNECTION_ALARM_QUALIFIER_UNIT_MACROS_SVH
`define DISCONNECTION_ALARM_QUALIFIER_UNIT_MACROS_SVH

// Same-cycle implication
`define DAQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/daq_pkg.sv
`timescale 1ns / 1ps

package daq_pkg;

    // Item op codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_HMI    = 2'd2;

    // Alarm state codes as reported on alarm_state
    localparam logic [1:0] ALM_FALSE     = 2'd0;
    localparam logic [1:0] ALM_DETECTED  = 2'd1;
    localparam logic [1:0] ALM_TRUE      = 2'd2;
    localparam logic [1:0] ALM_DISPLAYED = 2'd3;

    // Event codes as reported on alarm_event
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_RAISED = 2'd1;
    localparam logic [1:0] EV_ENDED  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRESS_SETPOINT = 2'd0;
    localparam logic [1:0] CFG_VOLUME_MIN     = 2'd1;
    localparam logic [1:0] CFG_FLOW_MAX       = 2'd2;
    localparam logic [1:0] CFG_ALARM_DELAY    = 2'd3;

    // Register widths
    localparam int SETPOINT_W = 12;
    localparam int VOLUME_W   = 16;
    localparam int FLOW_W     = 15;
    localparam int DELAY_W    = 16;

    // Reset values
    localparam int PRESS_SETPOINT_RST = 200;
    localparam logic [SETPOINT_W-1:0] LOW_PRESS_RST =
        SETPOINT_W'(PRESS_SETPOINT_RST * 8 / 10);
    localparam logic [VOLUME_W-1:0] VOLUME_MIN_RST  = 16'd20;
    localparam logic [FLOW_W-1:0]   FLOW_MAX_RST    = 15'd600;
    localparam logic [DELAY_W-1:0]  ALARM_DELAY_RST = 16'd1000;

    // floor(n/5) == (n * 0xCCCD) >> 18 for every n below 2^16
    localparam logic [15:0] RECIP_FIVE = 16'hCCCD;
    localparam int          RECIP_SHIFT = 18;

    // Fault thresholds handed to the compare stage
    typedef struct packed {
        logic [SETPOINT_W-1:0] low_press;
        logic [VOLUME_W-1:0]   volume_min;
        logic [FLOW_W-1:0]     flow_max;
    } thresh_t;

endpackage

>>> hdl/daq_fault_check.sv
`timescale 1ns / 1ps

// Disconnection fault compare: low pressure, or low volume with high flow.
module daq_fault_check
(
    input  logic signed [15:0] patient_pressure,
    input  logic signed [15:0] insp_flow,
    input  logic        [15:0] tidal_volume,
    input  daq_pkg::thresh_t   thresh,
    output logic               fault
);

    logic signed [16:0] press_ext;
    logic signed [16:0] low_ext;
    logic signed [15:0] flow_max_ext;
    logic               press_low;
    logic               leak;

    // Threshold is never negative, so zero-extend it into the signed compare
    assign press_ext    = 17'(patient_pressure);
    assign low_ext      = $signed({5'b0, thresh.low_press});
    assign flow_max_ext = $signed({1'b0, thresh.flow_max});

    assign press_low = (press_ext <= low_ext);
    assign leak      = (tidal_volume <= thresh.volume_min) && (insp_flow > flow_max_ext);
    assign fault     = press_low || leak;

endmodule

>>> hdl/disconnection_alarm_qualifier_unit.sv
`timescale 1ns / 1ps

// Disconnection alarm qualifier.
// Input channel (in_valid / in_stall) carries one item per beat: a tick, a
// sample (pressure, flow, volume) or an HMI "displayed" report. Every item
// gives exactly one result beat on the output channel (out_valid /
// out_stall): the alarm state after the item, a raise/end event and the
// high priority bit.
// An accepted item waits in the input register and passes the state update
// into the result register. Throughput: one item per cycle unless the
// receiver stalls; the two registers form a two-deep pipe. When the
// receiver stalls, the result register holds its beat and the input
// register takes one more item; in_stall rises only when both are full.
// The configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data) is
// always ready; the pressure set point is stored as its 80% threshold,
// computed on the write.
// Reset: registers return to set point 200, volume 20, flow 600, delay
// 1000; state false, countdown zero, priority clear, both channels empty.
module disconnection_alarm_qualifier_unit
(
    input  logic               clk,
    input  logic               rst_n,
    // input items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic        [1:0]  op,
    input  logic signed [15:0] patient_pressure,
    input  logic signed [15:0] insp_flow,
    input  logic        [15:0] tidal_volume,
    // results
    output logic               out_valid,
    input  logic               out_stall,
    output logic        [1:0]  alarm_state,
    output logic        [1:0]  alarm_event,
    output logic               high_priority,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [1:0]  cfg_index,
    input  logic        [15:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_FALSE     = daq_pkg::ALM_FALSE,
        ST_DETECTED  = daq_pkg::ALM_DETECTED,
        ST_TRUE      = daq_pkg::ALM_TRUE,
        ST_DISPLAYED = daq_pkg::ALM_DISPLAYED
    } state_t;

    // Configuration
    daq_pkg::thresh_t               thresh_reg;
    logic [daq_pkg::DELAY_W-1:0]    delay_reg;
    logic [13:0]                    setpoint_x4;
    logic [29:0]                    recip_prod;
    logic [daq_pkg::SETPOINT_W-1:0] low_press_new;
    logic                           cfg_wr;

    // Input register
    logic               in_valid_reg;
    logic [1:0]         op_reg;
    logic signed [15:0] pressure_reg;
    logic signed [15:0] flow_reg;
    logic [15:0]        volume_reg;

    // State and result
    state_t                      state_reg, state_next;
    logic [daq_pkg::DELAY_W-1:0] count_reg, count_next;
    logic                        prio_reg, prio_next;
    logic [1:0]                  event_reg, event_next;
    logic                        out_valid_reg;

    logic accept;
    logic advance;
    logic fault;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // set point * 8 / 10 == (set point * 4) / 5, divide by reciprocal
    assign setpoint_x4   = {cfg_data[daq_pkg::SETPOINT_W-1:0], 2'b00};
    assign recip_prod    = 30'(setpoint_x4) * 30'(daq_pkg::RECIP_FIVE);
    assign low_press_new = recip_prod[daq_pkg::RECIP_SHIFT +: daq_pkg::SETPOINT_W];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.low_press  <= daq_pkg::LOW_PRESS_RST;
            thresh_reg.volume_min <= daq_pkg::VOLUME_MIN_RST;
            thresh_reg.flow_max   <= daq_pkg::FLOW_MAX_RST;
            delay_reg             <= daq_pkg::ALARM_DELAY_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                daq_pkg::CFG_PRESS_SETPOINT: thresh_reg.low_press  <= low_press_new;
                daq_pkg::CFG_VOLUME_MIN:     thresh_reg.volume_min <= cfg_data;
                daq_pkg::CFG_FLOW_MAX:       thresh_reg.flow_max   <= cfg_data[daq_pkg::FLOW_W-1:0];
                daq_pkg::CFG_ALARM_DELAY:    delay_reg             <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Pipe control: the input register drains when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op;
            pressure_reg <= patient_pressure;
            flow_reg     <= insp_flow;
            volume_reg   <= tidal_volume;
        end
    end

    daq_fault_check u_fault
    (
        .patient_pressure (pressure_reg),
        .insp_flow        (flow_reg),
        .tidal_volume     (volume_reg),
        .thresh           (thresh_reg),
        .fault            (fault)
    );

    // Qualifier next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        prio_next  = prio_reg;
        event_next = daq_pkg::EV_NONE;
        case (op_reg)
            daq_pkg::OP_TICK:
            begin
                if (count_reg != '0)
                    count_next = count_reg - 1'b1;
            end
            daq_pkg::OP_SAMPLE:
            begin
                unique case (state_reg)
                    ST_FALSE:
                    begin
                        if (fault)
                        begin
                            state_next = ST_DETECTED;
                            count_next = delay_reg;
                        end
                    end
                    ST_DETECTED:
                    begin
                        if (!fault)
                            state_next = ST_FALSE;
                        else if (count_reg == '0)
                        begin
                            state_next = ST_TRUE;
                            event_next = daq_pkg::EV_RAISED;
                            prio_next  = 1'b1;
                        end
                    end
                    ST_DISPLAYED:
                    begin
                        if (!fault)
                        begin
                            state_next = ST_FALSE;
                            event_next = daq_pkg::EV_ENDED;
                            prio_next  = 1'b0;
                        end
                    end
                    default: ;  // true state waits for the HMI
                endcase
            end
            daq_pkg::OP_HMI:
            begin
                if (state_reg == ST_TRUE)
                    state_next = ST_DISPLAYED;
            end
            default: ;
        endcase
    end

    // State, valid flags and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_FALSE;
            count_reg     <= '0;
            prio_reg      <= 1'b0;
            event_reg     <= daq_pkg::EV_NONE;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                count_reg     <= count_next;
                prio_reg      <= prio_next;
                event_reg     <= event_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // State and priority only change together with a new result beat
    assign out_valid     = out_valid_reg;
    assign alarm_state   = state_reg;
    assign alarm_event   = event_reg;
    assign high_priority = prio_reg;

endmodule

>>> hdl/daq_checker.sv
`timescale 1ns / 1ps
`include "disconnection_alarm_qualifier_unit_macros.svh"

// Port-level checks on the qualifier's result channel.
module daq_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] alarm_state,
    input logic [1:0] alarm_event,
    input logic       high_priority
);

    logic [4:0] out_beat;
    logic       out_held;
    logic       prio_expect;
    logic       raise_beat;
    logic       end_beat;
    logic       in_true;
    logic       in_false;

    // Result payload and beat qualifiers
    assign out_beat    = {alarm_state, alarm_event, high_priority};
    assign out_held    = out_valid && out_stall;
    assign prio_expect = (alarm_state == daq_pkg::ALM_TRUE) ||
                         (alarm_state == daq_pkg::ALM_DISPLAYED);
    assign raise_beat  = out_valid && (alarm_event == daq_pkg::EV_RAISED);
    assign end_beat    = out_valid && (alarm_event == daq_pkg::EV_ENDED);
    assign in_true     = (alarm_state == daq_pkg::ALM_TRUE);
    assign in_false    = (alarm_state == daq_pkg::ALM_FALSE);

    // A stalled beat holds
    `DAQ_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_beat), "stalled beat changed")

    // Priority bit is set exactly in the true and displayed states
    `DAQ_ASSERT_IMP(a_prio_state, out_valid, high_priority == prio_expect, "priority bit mismatch")

    // A raise event lands in the true state
    `DAQ_ASSERT_IMP(a_raise_true, raise_beat, in_true, "raise event outside true state")

    // An end event lands in the false state
    `DAQ_ASSERT_IMP(a_end_false, end_beat, in_false, "end event outside false state")

endmodule

bind disconnection_alarm_qualifier_unit daq_checker u_daq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .alarm_state   (alarm_state),
    .alarm_event   (alarm_event),
    .high_priority (high_priority)
);

>>> test/disconnection_alarm_qualifier_unit_test.sv
`timescale 1ns / 1ps

module disconnection_alarm_qualifier_unit_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] pressure;
        logic signed [15:0] flow;
        logic [15:0]        volume;
    } alarm_item_t;

    typedef struct packed {
        logic [1:0] state;
        logic [1:0] evt;
        logic       prio;
    } alarm_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic        [1:0]  op = daq_pkg::OP_TICK;
    logic signed [15:0] patient_pressure = '0;
    logic signed [15:0] insp_flow = '0;
    logic        [15:0] tidal_volume = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic        [1:0]  alarm_state;
    logic        [1:0]  alarm_event;
    logic               high_priority;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic        [1:0]  cfg_index = daq_pkg::CFG_PRESS_SETPOINT;
    logic        [15:0] cfg_data = '0;

    // Predictor copy of the configuration (reset values)
    logic [11:0] set_point = 12'd200;
    logic [15:0] volume_lim = 16'd20;
    logic [14:0] flow_lim = 15'd600;
    logic [15:0] delay_load = 16'd1000;

    // Predictor copy of the alarm state
    logic [1:0]  alarm_q = daq_pkg::ALM_FALSE;
    logic [15:0] delay_cnt = '0;
    logic        prio_q = 1'b0;

    alarm_item_t   pend_q[$];
    alarm_result_t alarm_exp_q[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    logic hold_req = 1'b0;
    int items_total = 0;
    int results_seen = 0;
    int budget_used = 0;
    int err_count = 0;
    int cycles = 0;

    disconnection_alarm_qualifier_unit u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .patient_pressure (patient_pressure),
        .insp_flow        (insp_flow),
        .tidal_volume     (tidal_volume),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .alarm_state      (alarm_state),
        .alarm_event      (alarm_event),
        .high_priority    (high_priority),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    // Low pressure threshold: 80% of the set point, truncated
    function automatic int low_thr();
        return int'(set_point) * 8 / 10;
    endfunction

    // Advance the alarm qualifier by one beat and return the expected result
    function automatic alarm_result_t advance_alarm(logic [1:0] kind,
        logic signed [15:0] pr, logic signed [15:0] fl, logic [15:0] vol);
        alarm_result_t r;
        logic hit;
        r.evt = daq_pkg::EV_NONE;
        hit = (int'(pr) <= low_thr()) ||
              ((vol <= volume_lim) && (int'(fl) > int'(flow_lim)));
        case (kind)
            daq_pkg::OP_TICK:
            begin
                if (delay_cnt != 0)
                    delay_cnt = delay_cnt - 16'd1;
            end
            daq_pkg::OP_SAMPLE:
            begin
                case (alarm_q)
                    daq_pkg::ALM_FALSE:
                    begin
                        if (hit)
                        begin
                            alarm_q = daq_pkg::ALM_DETECTED;
                            delay_cnt = delay_load;
                        end
                    end
                    daq_pkg::ALM_DETECTED:
                    begin
                        if (!hit)
                            alarm_q = daq_pkg::ALM_FALSE;
                        else if (delay_cnt == 0)
                        begin
                            alarm_q = daq_pkg::ALM_TRUE;
                            r.evt = daq_pkg::EV_RAISED;
                            prio_q = 1'b1;
                        end
                    end
                    daq_pkg::ALM_DISPLAYED:
                    begin
                        if (!hit)
                        begin
                            alarm_q = daq_pkg::ALM_FALSE;
                            r.evt = daq_pkg::EV_ENDED;
                            prio_q = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            daq_pkg::OP_HMI:
            begin
                if (alarm_q == daq_pkg::ALM_TRUE)
                    alarm_q = daq_pkg::ALM_DISPLAYED;
            end
            default: ;
        endcase
        r.state = alarm_q;
        r.prio = prio_q;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Driver: one beat per handshake, pulled from the pending queue
    always @(posedge clk)
    begin
        alarm_item_t nxt;
        if (in_valid && !in_stall)
            alarm_exp_q.push_back(advance_alarm(op, patient_pressure, insp_flow,
                                                tidal_volume));
        if (!in_valid || !in_stall)
        begin
            if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt = pend_q.pop_front();
                in_valid <= 1'b1;
                op <= nxt.op;
                patient_pressure <= nxt.pressure;
                insp_flow <= nxt.flow;
                tidal_volume <= nxt.volume;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        alarm_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (alarm_exp_q.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = alarm_exp_q.pop_front();
                results_seen++;
                if (alarm_state !== want.state)
                    report_mismatch($sformatf("alarm_state %0d, expected %0d",
                                              alarm_state, want.state));
                if (alarm_event !== want.evt)
                    report_mismatch($sformatf("alarm_event %0d, expected %0d",
                                              alarm_event, want.evt));
                if (high_priority !== want.prio)
                    report_mismatch($sformatf("high_priority %0d, expected %0d",
                                              high_priority, want.prio));
            end
        end
        out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            daq_pkg::CFG_PRESS_SETPOINT: set_point = data[11:0];
            daq_pkg::CFG_VOLUME_MIN:     volume_lim = data;
            daq_pkg::CFG_FLOW_MAX:       flow_lim = data[14:0];
            daq_pkg::CFG_ALARM_DELAY:    delay_load = data;
            default: ;
        endcase
    endtask

    task automatic configure(input int sp, input int vmin, input int fmax, input int dly);
        write_reg(daq_pkg::CFG_PRESS_SETPOINT, 16'(sp));
        write_reg(daq_pkg::CFG_VOLUME_MIN, 16'(vmin));
        write_reg(daq_pkg::CFG_FLOW_MAX, 16'(fmax));
        write_reg(daq_pkg::CFG_ALARM_DELAY, 16'(dly));
    endtask

    task automatic push_item(input logic [1:0] kind, input int pr, input int fl,
                             input int vol);
        alarm_item_t it;
        it.op = kind;
        it.pressure = 16'(pr);
        it.flow = 16'(fl);
        it.volume = 16'(vol);
        pend_q.push_back(it);
        items_total++;
        if (kind != OP_UNUSED)
            budget_used++;
    endtask

    // Sample beat that does or does not show the disconnection fault
    task automatic push_sample(input bit fault);
        int low;
        int pr;
        int fl;
        int vol;
        low = low_thr();
        pr = int'($urandom_range(65535)) - 32768;
        fl = int'($urandom_range(65535)) - 32768;
        vol = int'($urandom_range(65535));
        if ($urandom_range(9) == 0)
            ;   // fully random fields
        else if (fault)
        begin
            if (flow_lim != 15'h7FFF && $urandom_range(1) == 1)
            begin
                // leak: low volume with high flow
                vol = int'($urandom_range(int'(volume_lim)));
                fl = int'(flow_lim) + 1 + int'($urandom_range(32766 - int'(flow_lim)));
            end
            else
                pr = int'($urandom_range(low + 32768)) - 32768;
        end
        else
        begin
            pr = low + 1 + int'($urandom_range(32766 - low));
            if (volume_lim != 16'hFFFF && $urandom_range(1) == 1)
                vol = int'(volume_lim) + 1 + int'($urandom_range(65534 - int'(volume_lim)));
            else
                fl = int'($urandom_range(int'(flow_lim) + 32768)) - 32768;
        end
        push_item(daq_pkg::OP_SAMPLE, pr, fl, vol);
    endtask

    // Detect, count down, raise, display and clear, with random content; some episodes clear early or skip the display
    task automatic push_episode();
        int n;
        if ($urandom_range(3) == 0)
            push_sample(1'b0);
        push_sample(1'b1);
        if ($urandom_range(9) == 0)
        begin
            push_sample(1'b0);  // fault gone before the alarm
            return;
        end
        if (delay_load > 12)
            n = $urandom_range(14);
        else
        begin
            n = int'(delay_load) + int'($urandom_range(1));
            if ($urandom_range(4) == 0 && n > 0)
                n = n - 2 < 0 ? 0 : n - 2;
        end
        repeat (n)
        begin
            push_item(daq_pkg::OP_TICK, int'($urandom()), int'($urandom()),
                      int'($urandom()));
            if ($urandom_range(4) == 0)
                push_sample(1'b1);
        end
        push_sample(1'b1);
        repeat ($urandom_range(2))
        begin
            if ($urandom_range(1) == 1)
                push_sample($urandom_range(1));
            else
                push_item(daq_pkg::OP_TICK, 0, 0, 0);
        end
        if ($urandom_range(9) != 0)
            push_item(daq_pkg::OP_HMI, int'($urandom()), int'($urandom()),
                      int'($urandom()));
        repeat ($urandom_range(3))
            push_sample(1'b1);
        push_sample(1'b0);
    endtask

    task automatic push_noise();
        int kind;
        kind = $urandom_range(9);
        if (kind < 3)
            push_sample($urandom_range(1));
        else if (kind < 5)
            push_item(daq_pkg::OP_TICK, int'($urandom()), int'($urandom()),
                      int'($urandom()));
        else if (kind < 7)
            push_item(daq_pkg::OP_HMI, int'($urandom()), int'($urandom()),
                      int'($urandom()));
        else if (kind < 8)
            push_item(OP_UNUSED, int'($urandom()), int'($urandom()), int'($urandom()));
        else
            push_item(daq_pkg::OP_SAMPLE, int'($urandom()), int'($urandom()),
                      int'($urandom()));
    endtask

    task automatic wait_drained();
        while (results_seen != items_total)
            @(posedge clk);
    endtask

    task automatic run_phase(input int sp, input int vmin, input int fmax, input int dly,
                             input int idle, input int stall, input int budget,
                             input bit long_hold);
        configure(sp, vmin, fmax, dly);
        idle_pct = idle;
        stall_pct = stall;
        if (long_hold)
        begin
            @(posedge clk);
            hold_req <= 1'b1;
            @(posedge clk);
            hold_req <= 1'b0;
        end
        budget_used = 0;
        while (budget_used < budget)
        begin
            if ($urandom_range(3) != 0)
                push_episode();
            else
                push_noise();
        end
        wait_drained();
    endtask

    // Run limit
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds: low pressure 160, volume 20, flow 600
        push_item(daq_pkg::OP_TICK, 0, 0, 0);                  // tick holds at zero
        push_item(daq_pkg::OP_SAMPLE, 161, 600, 20);           // flow not above max
        push_item(daq_pkg::OP_SAMPLE, 161, 601, 21);           // volume above min
        push_item(daq_pkg::OP_HMI, 0, 0, 0);                   // HMI ignored in false
        push_item(OP_UNUSED, -1, -1, 65535);                   // unused op ignored
        push_item(daq_pkg::OP_SAMPLE, 161, 601, 20);           // leak -> detected
        push_item(daq_pkg::OP_TICK, 0, 0, 0);
        push_item(daq_pkg::OP_SAMPLE, 160, 0, 65535);          // pressure at threshold
        push_item(daq_pkg::OP_SAMPLE, 32767, -32768, 0);       // cleared -> false
        push_item(daq_pkg::OP_SAMPLE, -32768, 32767, 65535);
        push_item(daq_pkg::OP_SAMPLE, 32767, 0, 0);
        wait_drained();

        // Zero delay: second fault sample raises
        configure(4000, 0, 0, 0);
        push_item(daq_pkg::OP_SAMPLE, 3200, 0, 1);
        push_item(daq_pkg::OP_SAMPLE, 0, 1, 0);
        push_item(daq_pkg::OP_SAMPLE, 3201, 0, 0);             // sample in true ignored
        push_item(daq_pkg::OP_HMI, 0, 0, 0);
        push_item(daq_pkg::OP_SAMPLE, -5, 0, 1);               // fault held while displayed
        push_item(OP_UNUSED, 0, 0, 0);
        push_item(daq_pkg::OP_SAMPLE, 3201, 1, 1);             // end of alarm
        wait_drained();

        // Countdown of two ticks
        write_reg(daq_pkg::CFG_ALARM_DELAY, 16'd2);
        push_item(daq_pkg::OP_SAMPLE, 0, 0, 0);
        push_item(daq_pkg::OP_TICK, 0, 0, 0);
        push_item(daq_pkg::OP_SAMPLE, 0, 0, 0);                // count not yet zero
        push_item(daq_pkg::OP_TICK, 0, 0, 0);
        push_item(daq_pkg::OP_SAMPLE, 0, 0, 0);                // raise
        push_item(daq_pkg::OP_HMI, 0, 0, 0);
        push_item(daq_pkg::OP_SAMPLE, 4000, 0, 65535);
        wait_drained();

        run_phase(1000, 100, 300, 3, 0, 0, 300, 1'b0);
        run_phase(0, 65535, 32767, 0, 87, 0, 250, 1'b0);
        run_phase(4000, 0, 0, 5, 0, 87, 250, 1'b0);
        run_phase(2500, 500, 1000, 1, 14, 14, 300, 1'b0);
        run_phase(300, 40, 200, 2, 0, 0, 250, 1'b1);
        run_phase(1234, 12345, 20000, 65535, 30, 30, 100, 1'b0);

        repeat (5) @(posedge clk);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
